@@ hdl/smx_pkg.sv @@
package smx_pkg;

  typedef enum logic [4:0] {
    OP_NOP   = 5'd0,
    OP_EXIT  = 5'd1,
    OP_JUMP  = 5'd2,
    OP_JIF   = 5'd3,
    OP_NOT   = 5'd4,
    OP_PUSHB = 5'd5,
    OP_PUSHW = 5'd6,
    OP_PUSHD = 5'd7,
    OP_PUSHQ = 5'd8,
    OP_STORE = 5'd9,
    OP_LOAD  = 5'd10,
    OP_POP   = 5'd11,
    OP_DUP   = 5'd12,
    OP_INC   = 5'd13,
    OP_DEC   = 5'd14,
    OP_PUTC  = 5'd15,
    OP_ADD   = 5'd16,
    OP_SUB   = 5'd17,
    OP_MUL   = 5'd18,
    OP_EQ    = 5'd19
  } op_e;

  typedef enum logic [3:0] {
    ST_RUN     = 4'd0,
    ST_EXIT    = 4'd1,
    ST_UNKNOWN = 4'd2,
    ST_OVER    = 4'd3,
    ST_UNDER   = 4'd4,
    ST_TEST    = 4'd5,
    ST_CHAR    = 4'd6,
    ST_ADDR    = 4'd7,
    ST_PAST    = 4'd8
  } status_e;

  localparam int OpWidth   = 5;
  localparam int PcWidth   = 16;
  localparam int WordWidth = 64;
  localparam int LenWidth  = 4;
  localparam int DepthOutW = 10;
  localparam int CharWidth = 8;
  localparam int OpLast    = 19;

  // decoded instruction handed from front to back
  typedef struct packed {
    logic                 known;
    op_e                  op;
    logic [WordWidth-1:0] imm;
    logic [WordWidth-1:0] value;
    logic [LenWidth-1:0]  len;
    logic                 addr_ok;
  } instr_t;

endpackage

@@ hdl/smx_ram.sv @@
module smx_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/smx_front.sv @@
module smx_front #(
  parameter int DATA_WORDS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [smx_pkg::OpWidth-1:0]         operation_i,
  input  logic [smx_pkg::WordWidth-1:0]       immediate_i,
  output logic                                head_valid_o,
  output smx_pkg::instr_t                     head_o,
  input  logic                                pop_i
);

  smx_pkg::instr_t dec;
  smx_pkg::instr_t q_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push;

  always_comb begin
    dec         = '0;
    dec.imm     = immediate_i;
    dec.known   = (operation_i <= 5'(smx_pkg::OpLast));
    dec.op      = dec.known ? smx_pkg::op_e'(operation_i) : smx_pkg::OP_NOP;
    dec.addr_ok = (immediate_i < 64'(DATA_WORDS));
    dec.len     = 4'd1;
    dec.value   = immediate_i;
    case (dec.op)
      smx_pkg::OP_PUSHB: begin
        dec.len   = 4'd2;
        dec.value = {56'd0, immediate_i[7:0]};
      end
      smx_pkg::OP_PUSHW: begin
        dec.len   = 4'd3;
        dec.value = {48'd0, immediate_i[15:0]};
      end
      smx_pkg::OP_PUSHD: begin
        dec.len   = 4'd5;
        dec.value = {32'd0, immediate_i[31:0]};
      end
      smx_pkg::OP_PUSHQ: dec.len = 4'd9;
      smx_pkg::OP_STORE, smx_pkg::OP_LOAD: dec.len = 4'd2;
      default: dec.len = 4'd1;
    endcase
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

@@ hdl/smx_back.sv @@
module smx_back #(
  parameter int STACK_DEPTH   = 1024,
  parameter int DATA_WORDS    = 256,
  parameter int PROGRAM_LIMIT = 65527
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            head_valid_i,
  input  smx_pkg::instr_t                 head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [smx_pkg::PcWidth-1:0]     next_pc_o,
  output logic [3:0]                      status_o,
  output logic [smx_pkg::WordWidth-1:0]   top_value_o,
  output logic [smx_pkg::DepthOutW-1:0]   stack_depth_o,
  output logic                            char_valid_o,
  output logic [smx_pkg::CharWidth-1:0]   char_code_o
);

  localparam int SpW = $clog2(STACK_DEPTH);
  localparam int DaW = $clog2(DATA_WORDS);
  localparam logic [SpW-1:0] SpMax = SpW'(STACK_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e           state_q;
  logic [15:0]      pc_q, pc_n;
  logic [SpW-1:0]   sp_q, sp_n;
  logic [63:0]      top_q, top_n, slot0_q;
  smx_pkg::status_e halt_q, st;
  logic [DATA_WORDS-1:0] dvalid_q;
  logic             dval_q;
  logic [63:0]      p0_q;
  logic [31:0]      p1_q, p2_q;
  logic [63:0]      m0, m1, m2;

  logic             stk_we, dat_we, chv;
  logic [SpW-1:0]   stk_waddr;
  logic [63:0]      stk_wdata, stk_rdata, dat_rdata, sec, dval, mul_res, t;
  logic [DaW-1:0]   daddr;
  logic             issue, fire;

  logic             out_valid_q, chv_q;
  logic [15:0]      opc_q;
  logic [3:0]       ost_q;
  logic [63:0]      otop_q;
  logic [SpW-1:0]   osp_q;
  logic [7:0]       chc_q;

  assign daddr = head_i.imm[DaW-1:0];
  assign issue = (state_q == S_IDLE) && head_valid_i;
  assign fire  = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign pop_o = fire;

  smx_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (issue),
    .raddr_i(sp_q - SpW'(1)),
    .rdata_o(stk_rdata)
  );

  smx_ram #(.WIDTH(64), .DEPTH(DATA_WORDS)) u_data (
    .clk_i  (clk_i),
    .we_i   (dat_we),
    .waddr_i(daddr),
    .wdata_i(top_q),
    .re_i   (issue),
    .raddr_i(daddr),
    .rdata_o(dat_rdata)
  );

  assign t       = top_q;
  assign sec     = (sp_q == SpW'(1)) ? slot0_q : stk_rdata;
  assign dval    = dval_q ? dat_rdata : 64'd0;
  assign m0      = 64'(sec[31:0]) * 64'(t[31:0]);
  assign m1      = 64'(sec[31:0]) * 64'(t[63:32]);
  assign m2      = 64'(sec[63:32]) * 64'(t[31:0]);
  assign mul_res = p0_q + {p1_q + p2_q, 32'd0};

  always_comb begin
    st        = smx_pkg::ST_RUN;
    pc_n      = pc_q;
    sp_n      = sp_q;
    top_n     = top_q;
    stk_we    = 1'b0;
    stk_waddr = sp_q;
    stk_wdata = top_q;
    dat_we    = 1'b0;
    chv       = 1'b0;
    if (halt_q != smx_pkg::ST_RUN) begin
      st = halt_q;
    end else if (pc_q > 16'(PROGRAM_LIMIT)) begin
      st = smx_pkg::ST_PAST;
    end else if (!head_i.known) begin
      st = smx_pkg::ST_UNKNOWN;
    end else begin
      case (head_i.op)
        smx_pkg::OP_NOP:  pc_n = pc_q + 16'd1;
        smx_pkg::OP_EXIT: st = smx_pkg::ST_EXIT;
        smx_pkg::OP_JUMP: pc_n = head_i.imm[15:0];
        smx_pkg::OP_JIF: begin
          if (sp_q == '0) begin
            st = smx_pkg::ST_UNDER;
          end else if (t > 64'd1) begin
            st = smx_pkg::ST_TEST;
          end else begin
            pc_n  = t[0] ? head_i.imm[15:0] : pc_q + 16'd3;
            sp_n  = sp_q - SpW'(1);
            top_n = sec;
          end
        end
        smx_pkg::OP_NOT: begin
          if (t > 64'd1) begin
            st = smx_pkg::ST_TEST;
          end else begin
            top_n     = {63'd0, ~t[0]};
            stk_we    = 1'b1;
            stk_wdata = top_n;
            pc_n      = pc_q + 16'd1;
          end
        end
        smx_pkg::OP_PUSHB, smx_pkg::OP_PUSHW, smx_pkg::OP_PUSHD, smx_pkg::OP_PUSHQ,
        smx_pkg::OP_DUP, smx_pkg::OP_LOAD: begin
          if (head_i.op == smx_pkg::OP_LOAD && !head_i.addr_ok) begin
            st = smx_pkg::ST_ADDR;
          end else if (sp_q == SpMax) begin
            st = smx_pkg::ST_OVER;
          end else if (head_i.op == smx_pkg::OP_DUP && sp_q == '0) begin
            st = smx_pkg::ST_UNDER;
          end else begin
            case (head_i.op)
              smx_pkg::OP_DUP:  top_n = t;
              smx_pkg::OP_LOAD: top_n = dval;
              default:          top_n = head_i.value;
            endcase
            sp_n      = sp_q + SpW'(1);
            stk_we    = 1'b1;
            stk_waddr = sp_n;
            stk_wdata = top_n;
            pc_n      = pc_q + 16'(head_i.len);
          end
        end
        smx_pkg::OP_STORE: begin
          if (!head_i.addr_ok) begin
            st = smx_pkg::ST_ADDR;
          end else begin
            dat_we = 1'b1;
            pc_n   = pc_q + 16'd2;
          end
        end
        smx_pkg::OP_POP: begin
          if (sp_q == '0) begin
            st = smx_pkg::ST_UNDER;
          end else begin
            sp_n  = sp_q - SpW'(1);
            top_n = sec;
            pc_n  = pc_q + 16'd1;
          end
        end
        smx_pkg::OP_INC, smx_pkg::OP_DEC: begin
          if (sp_q == '0) begin
            st = smx_pkg::ST_UNDER;
          end else begin
            top_n     = (head_i.op == smx_pkg::OP_INC) ? t + 64'd1 : t - 64'd1;
            stk_we    = 1'b1;
            stk_wdata = top_n;
            pc_n      = pc_q + 16'd1;
          end
        end
        smx_pkg::OP_PUTC: begin
          if (sp_q == '0) begin
            st = smx_pkg::ST_UNDER;
          end else if (t > 64'd255) begin
            st = smx_pkg::ST_CHAR;
          end else begin
            chv  = 1'b1;
            pc_n = pc_q + 16'd1;
          end
        end
        smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_EQ: begin
          if (sp_q < SpW'(2)) begin
            st = smx_pkg::ST_UNDER;
          end else begin
            case (head_i.op)
              smx_pkg::OP_ADD: top_n = sec + t;
              smx_pkg::OP_SUB: top_n = sec - t;
              smx_pkg::OP_MUL: top_n = mul_res;
              default:         top_n = {63'd0, sec == t};
            endcase
            sp_n      = sp_q - SpW'(1);
            stk_we    = 1'b1;
            stk_waddr = sp_n;
            stk_wdata = top_n;
            pc_n      = pc_q + 16'd1;
          end
        end
        default: st = smx_pkg::ST_UNKNOWN;
      endcase
    end
    // only commit in the execute cycle that fires
    if (!fire) begin
      stk_we = 1'b0;
      dat_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      dval_q <= dvalid_q[daddr];
    end
    if (state_q == S_MUL) begin
      p0_q <= m0;
      p1_q <= m1[31:0];
      p2_q <= m2[31:0];
    end
    if (fire) begin
      opc_q  <= pc_n;
      ost_q  <= st;
      otop_q <= top_n;
      osp_q  <= sp_n;
      chc_q  <= chv ? t[7:0] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      sp_q        <= '0;
      top_q       <= '0;
      slot0_q     <= '0;
      halt_q      <= smx_pkg::ST_RUN;
      dvalid_q    <= '0;
      out_valid_q <= 1'b0;
      chv_q       <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (head_valid_i) begin
            state_q <= (head_i.op == smx_pkg::OP_MUL) ? S_MUL : S_EXEC;
          end
        end
        S_MUL:  state_q <= S_EXEC;
        S_EXEC: begin
          if (fire) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (fire) begin
        pc_q   <= pc_n;
        sp_q   <= sp_n;
        top_q  <= top_n;
        halt_q <= st;
        chv_q  <= chv;
        if (stk_we && stk_waddr == '0) begin
          slot0_q <= stk_wdata;
        end
        if (dat_we) begin
          dvalid_q[daddr] <= 1'b1;
        end
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = opc_q;
  assign status_o      = ost_q;
  assign top_value_o   = otop_q;
  assign stack_depth_o = 10'(osp_q);
  assign char_valid_o  = chv_q;
  assign char_code_o   = chc_q;

endmodule

@@ hdl/stack_machine_execute_unit.sv @@
// Flow: a transaction waits in the front queue, is issued from the idle state, which reads
// the second stack entry and the data RAM, passes a multiply state for mul only, and commits
// in the execute state once the output register is empty or not stalled; results register there.
// Instructions execute one at a time; the front queue takes new ones until it is full.
// Reset: asynchronous, clears pc, stack pointer, top of stack, status and data-word valid
// bits at once; no clearing pass, transactions are taken from the first cycle after reset.
module stack_machine_execute_unit #(
  parameter int STACK_DEPTH   = 1024,
  parameter int DATA_WORDS    = 256,
  parameter int PROGRAM_LIMIT = 65527
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  operation_i,
  input  logic [63:0] immediate_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] next_pc_o,
  output logic [3:0]  status_o,
  output logic [63:0] top_value_o,
  output logic [9:0]  stack_depth_o,
  output logic        char_valid_o,
  output logic [7:0]  char_code_o
);

  logic            head_valid;
  smx_pkg::instr_t head;
  logic            pop;

  smx_front #(.DATA_WORDS(DATA_WORDS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .immediate_i (immediate_i),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  smx_back #(
    .STACK_DEPTH  (STACK_DEPTH),
    .DATA_WORDS   (DATA_WORDS),
    .PROGRAM_LIMIT(PROGRAM_LIMIT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .next_pc_o    (next_pc_o),
    .status_o     (status_o),
    .top_value_o  (top_value_o),
    .stack_depth_o(stack_depth_o),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o)
  );

endmodule
